// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker in cnds_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define CHK_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define CHK_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ===== rtl/core/cnds_pkg.sv =====
// Package with the types and constants of the digit-set counter.
package cnds_pkg;
    localparam int MaxDigits = 10;
    localparam int LimitW = 31;
    localparam int CountW = 31;
    localparam int MaskW = 9;
    localparam int KW = 4;
    localparam int DigW = 4;
    localparam int PosW = 4;
    // Wide enough for 10^MaxDigits - 1 and for k^MaxDigits sums below the cap.
    localparam int AccW = 36;
    localparam int QueueDepth = 2;

    typedef logic [DigW-1:0] digit_t;
    typedef digit_t [MaxDigits-1:0] digits_t;

    // Classified query passed from the front end to the back end.
    typedef struct packed {
        digits_t          digs;      // least significant digit first
        logic [PosW-1:0]  len;       // number of decimal digits, at least one
        logic [MaskW-1:0] mask;
        logic [KW-1:0]    k;         // allowed digit count
        logic             zero;      // empty set or zero limit
    } query_t;

    // Number of allowed digits strictly below d.
    function automatic logic [KW-1:0] count_below(input digit_t d,
                                                  input logic [MaskW-1:0] m);
        logic [KW-1:0] c;
        c = '0;
        for (int i = 1; i <= 9; i++) begin
            if (i < int'(d) && m[i-1]) c = c + KW'(1);
        end
        return c;
    endfunction

    function automatic logic digit_ok(input digit_t d, input logic [MaskW-1:0] m);
        logic r;
        r = 1'b0;
        if (d >= DigW'(1) && d <= DigW'(9)) r = m[d - DigW'(1)];
        return r;
    endfunction
endpackage

// ===== rtl/core/cnds_front.sv =====
// Front end: split the limit into decimal digits, one digit per stage, and classify.
module cnds_front (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [cnds_pkg::LimitW-1:0] in_limit,
    input  logic [cnds_pkg::MaskW-1:0]  mask,
    output logic                        out_valid,
    input  logic                        out_ready,
    output cnds_pkg::query_t            out_query
);
    localparam int N = cnds_pkg::MaxDigits;
    localparam int AW = cnds_pkg::AccW;

    logic [N:0]            vld_reg;
    logic [AW-1:0]         rem_reg  [N+1];
    cnds_pkg::digits_t     digs_reg [N+1];
    logic [cnds_pkg::PosW-1:0] len_reg [N+1];
    logic [cnds_pkg::MaskW-1:0] msk_reg [N+1];
    logic                  zero_reg [N+1];
    logic                  adv;

    // The whole pipe moves together; it stalls when the last stage is held.
    assign adv = !vld_reg[N] || out_ready;
    assign in_ready = adv;
    assign out_valid = vld_reg[N];

    logic [AW-1:0] cap;
    logic [AW-1:0] lim_ext;
    assign cap = AW'(64'd9999999999);
    assign lim_ext = AW'(in_limit);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[N-1:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            rem_reg[0]  <= (lim_ext > cap) ? cap : lim_ext;
            digs_reg[0] <= '0;
            len_reg[0]  <= '0;
            msk_reg[0]  <= mask;
            zero_reg[0] <= (in_limit == '0) || (mask == '0);
            for (int s = 0; s < N; s++) begin
                // Peel one digit: divide by ten via a constant reciprocal.
                // The remainder never exceeds 31 bits, so a 32-bit constant is exact.
                logic [AW-1:0] q;
                logic [AW-1:0] r;
                cnds_pkg::digits_t dv;
                q = AW'((64'(rem_reg[s][30:0]) * 64'(32'hCCCC_CCCD)) >> 35);
                r = rem_reg[s] - q * AW'(10);
                if (r >= AW'(10)) begin
                    q = q + AW'(1);
                    r = r - AW'(10);
                end
                dv = digs_reg[s];
                dv[s] = cnds_pkg::DigW'(r);
                rem_reg[s+1] <= q;
                digs_reg[s+1] <= dv;
                len_reg[s+1] <= (rem_reg[s] != '0 || s == 0) ?
                                cnds_pkg::PosW'(s + 1) : len_reg[s];
                msk_reg[s+1] <= msk_reg[s];
                zero_reg[s+1] <= zero_reg[s];
            end
        end
    end

    always_comb begin
        logic [cnds_pkg::KW-1:0] k;
        k = '0;
        for (int i = 0; i < cnds_pkg::MaskW; i++) k = k + cnds_pkg::KW'(msk_reg[N][i]);
        out_query.digs = digs_reg[N];
        out_query.len  = len_reg[N];
        out_query.mask = msk_reg[N];
        out_query.k    = k;
        out_query.zero = zero_reg[N];
    end
endmodule

// ===== rtl/core/cnds_queue.sv =====
// Short queue between the front end and the back end.
module cnds_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  cnds_pkg::query_t in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output cnds_pkg::query_t out_data
);
    localparam int D = cnds_pkg::QueueDepth;
    cnds_pkg::query_t mem_reg [D];
    logic [$clog2(D)-1:0] wp_reg, rp_reg;
    logic [$clog2(D):0]   cnt_reg;
    logic wr, rd;

    assign in_ready  = cnt_reg != ($clog2(D)+1)'(D);
    assign out_valid = cnt_reg != '0;
    assign out_data  = mem_reg[rp_reg];
    assign wr = in_valid && in_ready;
    assign rd = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end else begin
            if (wr) wp_reg <= wp_reg + 1'b1;
            if (rd) rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + ($clog2(D)+1)'(wr) - ($clog2(D)+1)'(rd);
        end
    end

    always_ff @(posedge aclk) begin
        if (wr) mem_reg[wp_reg] <= in_data;
    end
endmodule

// ===== rtl/core/cnds_back.sv =====
// Back end: tight digit walk, one digit position per stage, most significant first.
module cnds_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  cnds_pkg::query_t            in_query,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [cnds_pkg::CountW-1:0] out_count
);
    localparam int N = cnds_pkg::MaxDigits;
    localparam int AW = cnds_pkg::AccW;

    logic [N:0]        vld_reg;
    cnds_pkg::query_t  q_reg   [N+1];
    logic [AW-1:0]     tot_reg [N+1];  // running total, Horner form in k
    logic              run_reg [N+1];  // walk not yet stopped
    logic              adv;

    assign adv = !vld_reg[N] || out_ready;
    assign in_ready = adv;
    assign out_valid = vld_reg[N];

    always_ff @(posedge aclk) begin
        if (!aresetn) vld_reg <= '0;
        else if (adv) vld_reg <= {vld_reg[N-1:0], in_valid};
    end

    // Stage s handles digit position p = MaxDigits-1-s. Each stage scales the
    // total by k and adds this position's coefficient: the allowed digits below
    // the digit while the walk runs, plus one for every position 1..len-1 (the
    // shorter lengths). After the last stage the total is the sum of the
    // coefficients times k^p.
    always_ff @(posedge aclk) begin
        if (adv) begin
            q_reg[0]   <= in_query;
            tot_reg[0] <= '0;
            run_reg[0] <= 1'b1;
            for (int s = 0; s < N; s++) begin
                logic [cnds_pkg::PosW-1:0] p;
                cnds_pkg::digit_t d;
                logic [AW-1:0] add;
                logic [AW-1:0] geo;
                p = cnds_pkg::PosW'(N - 1 - s);
                d = q_reg[s].digs[N-1-s];
                add = '0;
                if (run_reg[s] && p < q_reg[s].len) begin
                    add = AW'(cnds_pkg::count_below(d, q_reg[s].mask));
                end
                geo = (p != '0 && p < q_reg[s].len) ? AW'(1) : '0;
                q_reg[s+1]   <= q_reg[s];
                tot_reg[s+1] <= tot_reg[s] * AW'(q_reg[s].k) + add + geo;
                run_reg[s+1] <= run_reg[s] &&
                    !(p < q_reg[s].len && !cnds_pkg::digit_ok(d, q_reg[s].mask));
            end
        end
    end

    always_comb begin
        logic [AW-1:0] t;
        t = tot_reg[N] + AW'(run_reg[N]);
        out_count = q_reg[N].zero ? '0 : cnds_pkg::CountW'(t);
    end
endmodule

// ===== rtl/core/count_numbers_from_digit_set.sv =====
// Top level of the digit-set counter.
// Usage:
//   Write digit_mask (bit d-1 allows digit d) through cfg_we/cfg_data while
//   the block is idle; it resets to zero, so every count is zero until written.
//   Present each limit on s_axis_tdata with s_axis_tvalid; an item is taken
//   when s_axis_tready is high at the rising edge of aclk.
//   Each count comes out on m_axis_tdata, one result per limit, in order.
// Pipeline and rate:
//   A front pipe (an input register and ten digit stages) splits the limit
//   into decimal digits, a two-entry queue adds one register and decouples it
//   from the back pipe (an input register and ten position stages), which
//   walks the digits most significant first. One item is accepted every
//   cycle while m_axis_tready stays high.
// Reset and stalls:
//   aresetn (synchronous, active low) empties both pipes and the queue.
//   When m_axis_tready is low the back pipe holds, the queue fills, and then
//   the front pipe holds and s_axis_tready falls; no item is lost.
module count_numbers_from_digit_set (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [8:0]  cfg_data,      // digit_mask
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // [30:0] limit, [31] zero fill
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata   // [30:0] count, [31] zero fill
);
    logic [cnds_pkg::MaskW-1:0] mask_reg;
    logic f_valid, f_ready, b_valid, b_ready;
    cnds_pkg::query_t f_q, b_q;
    logic [cnds_pkg::CountW-1:0] count;

    // Hold the allowed-digit mask.
    always_ff @(posedge aclk) begin
        if (!aresetn) mask_reg <= '0;
        else if (cfg_we) mask_reg <= cfg_data;
    end

    cnds_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .in_limit(s_axis_tdata[cnds_pkg::LimitW-1:0]), .mask(mask_reg),
        .out_valid(f_valid), .out_ready(f_ready), .out_query(f_q)
    );

    cnds_queue u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(f_valid), .in_ready(f_ready), .in_data(f_q),
        .out_valid(b_valid), .out_ready(b_ready), .out_data(b_q)
    );

    cnds_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(b_valid), .in_ready(b_ready), .in_query(b_q),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_count(count)
    );

    // Pad the 31-bit count with a zero to 32 bits.
    assign m_axis_tdata = {1'b0, count};
endmodule

// ===== rtl/core/cnds_checker.sv =====
// Port-level checker for the digit-set counter, with its bind.
`include "assert_macros.svh"
module cnds_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);
    `CHK_IMPL(a_pad, aclk, aresetn, m_axis_tvalid, m_axis_tdata[31] == 1'b0, "pad bit set")
    `CHK_NEXT(a_hold, aclk, aresetn, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "valid dropped")
    `CHK_NEXT(a_stable, aclk, aresetn, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata), "data moved")
    `CHK_IMPL(a_rdy, aclk, aresetn, s_axis_tvalid, !$isunknown(s_axis_tready), "ready unknown")
endmodule

bind count_numbers_from_digit_set cnds_checker u_chk (
    .aclk(aclk), .aresetn(aresetn),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);
